// ----- rtl/sm3_pkg.sv -----
// SM3 package: payload structs, constants, round helper functions.
// Used by every module of the SM3 hash engine; no dependencies.
package sm3_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } sm3_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } sm3_out_t;

  localparam logic [255:0] IV = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  // Byte source the datapath writes into the block buffer.
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic      put_byte;    // write one byte into the block
    byte_src_t src;
    logic      count_len;   // add 8 to the bit length
    logic      latch_len;   // snapshot the bit length for the trailer
    logic      start_comp;  // load working regs from chain value
    logic      round;       // run one compression round
    logic      finish_comp; // fold working regs into chain value
    logic      restart;     // chain value and length back to reset
  } sm3_cmd_t;

  typedef struct packed {
    logic [5:0] byte_pos;
    logic       last_round;
  } sm3_status_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ----- rtl/sm3_datapath.sv -----
// SM3 datapath: block buffer, on-the-fly message expansion window,
// working registers, chain value and bit length. Depends on sm3_pkg.
module sm3_datapath import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sm3_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  out_sel,
  output sm3_status_t status,
  output logic [31:0] digest_word
);

  logic [31:0] blk [16];     // block words, written bytewise
  logic [31:0] win [16];     // expansion window, win[0] = W[j]
  logic [31:0] r [8];
  logic [31:0] cv [8];
  logic [63:0] bit_len;
  logic [63:0] len_snap;
  logic [5:0]  pos;
  logic [5:0]  rnd;
  logic [7:0]  byte_in;
  logic [31:0] w_new, w_j, wp_j, t_j, a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    case (cmd.src)
      SRC_DATA: byte_in = data_byte;
      SRC_PAD:  byte_in = PAD_MARK;
      SRC_ZERO: byte_in = 8'h00;
      SRC_LEN:  byte_in = len_snap[63 - 8*pos[2:0] -: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  always_comb begin
    w_new = perm1(win[0] ^ win[7] ^ rotl(win[13], 5'd15)) ^ rotl(win[3], 5'd7) ^ win[10];
    w_j   = win[0];
    wp_j  = win[0] ^ win[4];
    t_j   = (rnd < 6'd16) ? T_LOW : T_HIGH;
    a12   = rotl(r[0], 5'd12);
    ss1   = rotl(a12 + r[4] + rotl(t_j, rnd[4:0]), 5'd7);
    ss2   = ss1 ^ a12;
    if (rnd < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + wp_j;
    tt2 = gg + r[7] + ss1 + w_j;
  end

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      if (pos[1:0] == 2'd0)
        blk[pos[5:2]] <= {byte_in, 24'h0};
      else
        blk[pos[5:2]][31 - 8*pos[1:0] -: 8] <= byte_in;
    end
    if (cmd.start_comp) begin
      for (int i = 0; i < 16; i++) win[i] <= blk[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_new;
    end
    if (cmd.latch_len) len_snap <= bit_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= IV[255 - 32*i -: 32];
        r[i]  <= '0;
      end
      bit_len <= '0;
      pos     <= '0;
      rnd     <= '0;
    end else begin
      if (cmd.put_byte) pos <= pos + 6'd1;
      if (cmd.count_len) bit_len <= bit_len + 64'd8;
      if (cmd.start_comp) begin
        for (int i = 0; i < 8; i++) r[i] <= cv[i];
        rnd <= '0;
      end else if (cmd.round) begin
        r[3] <= r[2];
        r[2] <= rotl(r[1], 5'd9);
        r[1] <= r[0];
        r[0] <= tt1;
        r[7] <= r[6];
        r[6] <= rotl(r[5], 5'd19);
        r[5] <= r[4];
        r[4] <= perm0(tt2);
        rnd  <= rnd + 6'd1;
      end
      if (cmd.finish_comp) begin
        for (int i = 0; i < 8; i++) cv[i] <= cv[i] ^ r[i];
      end
      if (cmd.restart) begin
        for (int i = 0; i < 8; i++) cv[i] <= IV[255 - 32*i -: 32];
        bit_len <= '0;
        pos     <= '0;
      end
    end
  end

  assign status.byte_pos   = pos;
  assign status.last_round = (rnd == 6'd63);
  assign digest_word       = cv[out_sel];

endmodule

// ----- rtl/sm3_ctrl.sv -----
// SM3 controller: input handshake, padding sequence, round scheduling
// and digest output. Depends on sm3_pkg.
module sm3_ctrl import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  sm3_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_sel,
  output sm3_cmd_t    cmd,
  input  sm3_status_t status
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_FOLD  = 7'b0001000,
    S_PAD   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // Padding phases, kept in idx while the trailer is written.
  localparam logic [2:0] PH_MARK    = 3'd0;  // 0x80 mark still to write
  localparam logic [2:0] PH_TRAILER = 3'd1;  // length written, block is the last
  localparam logic [2:0] PH_LEN     = 3'd2;  // zero fill, length fits in this block
  localparam logic [2:0] PH_FILL    = 3'd3;  // zero fill, length goes in next block

  state_t state, state_next;
  logic   padding, padding_next;  // message ended, trailer in progress
  logic [2:0] idx, idx_next;

  logic take;
  assign in_stall  = (state != S_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_valid = (state == S_EMIT);
  assign out_sel   = idx;

  always_comb begin
    state_next   = state;
    padding_next = padding;
    idx_next     = idx;
    cmd          = '0;
    cmd.src      = SRC_DATA;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (in_data.byte_valid) begin
            cmd.put_byte  = 1'b1;
            cmd.count_len = 1'b1;
          end
          if (in_data.last) begin
            padding_next = 1'b1;
            state_next   = S_PAD;
          end
          if (in_data.byte_valid && status.byte_pos == 6'd63) state_next = S_START;
        end
      end
      S_START: begin
        cmd.start_comp = 1'b1;
        state_next     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (status.last_round) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.finish_comp = 1'b1;
        if (!padding) begin
          state_next = S_IDLE;
        end else if (idx == PH_TRAILER) begin
          state_next = S_EMIT;
          idx_next   = 3'd0;
        end else begin
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        cmd.put_byte = 1'b1;
        case (idx)
          PH_MARK: begin
            // write the mark and snapshot the length; a mark at 56 or later
            // leaves no room for the length in this block
            cmd.src       = SRC_PAD;
            cmd.latch_len = 1'b1;
            idx_next      = (status.byte_pos >= 6'd56) ? PH_FILL : PH_LEN;
          end
          PH_FILL: cmd.src = SRC_ZERO;
          default: cmd.src = (status.byte_pos >= 6'd56) ? SRC_LEN : SRC_ZERO;
        endcase
        if (status.byte_pos == 6'd63) begin
          state_next = S_START;
          idx_next   = (idx == PH_LEN) ? PH_TRAILER : PH_LEN;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.restart  = 1'b1;
        padding_next = 1'b0;
        idx_next     = 3'd0;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      padding <= 1'b0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      padding <= padding_next;
      idx     <= idx_next;
    end
  end

endmodule

// ----- rtl/sm3_hash_engine.sv -----
// SM3 hash engine top level: joins the controller and the datapath.
// Depends on sm3_pkg, sm3_ctrl and sm3_datapath.
//
// Usage:
//   The input channel (in_valid / in_stall / in_data) takes one transfer per
//   message byte; byte_valid marks a real byte, last ends the message. A
//   transfer with last may carry no byte; it still ends the message.
//   After last the engine pads the message, compresses the trailer block(s)
//   and presents the eight digest words on the output channel (out_valid /
//   out_stall / out_data), most significant word first, final_word on the
//   eighth. The chain value then returns to the initial vector, the length to zero.
// Timing:
//   A byte that does not fill a block is taken without a stall. The 64th
//   byte of a block holds in_stall through one load, 64 rounds of the
//   single round unit and one fold into the chain value. After last,
//   padding writes one byte per cycle up to the block end, and each padded
//   block is then compressed (two blocks when the mark lands at byte 56 or
//   later). Digest words leave one per cycle while out_stall is low, and a
//   restart state follows the eighth before input reopens.
// Reset and stall:
//   rst (synchronous) returns the chain value to the initial vector and the
//   controller to idle. in_stall is high whenever the engine is busy; while
//   out_stall is high the current digest word holds.
module sm3_hash_engine import sm3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  sm3_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sm3_out_t out_data
);

  sm3_cmd_t    cmd;
  sm3_status_t status;
  logic [2:0]  out_sel;
  logic [31:0] digest_word;

  sm3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_sel   (out_sel),
    .cmd       (cmd),
    .status    (status)
  );

  sm3_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (in_data.data_byte),
    .out_sel     (out_sel),
    .status      (status),
    .digest_word (digest_word)
  );

  assign out_data.digest_word = digest_word;
  assign out_data.word_index  = out_sel;
  assign out_data.final_word  = (out_sel == 3'd7);

endmodule

// ----- bench/sm3_digest_checker.sv -----
`timescale 1ns / 1ps
// Digest checker for the SM3 hash engine: watches both channels, models the hash.
// Depends on sm3_pkg; instantiated beside the engine by sm3_hash_engine_test.
module sm3_digest_checker import sm3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  sm3_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  sm3_out_t out_data,
  output int       fail_count,
  output int       pending
);

  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [63:0] bit_len;
  logic [5:0]  pos;
  sm3_out_t    digest_q[$];

  function automatic logic [31:0] rl(input logic [31:0] x, input int n);
    return (n % 32 == 0) ? x : ((x << (n % 32)) | (x >> (32 - n % 32)));
  endfunction

  task automatic compress();
    logic [31:0] w [68];
    logic [31:0] r [8];
    logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2, p;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++) begin
      p = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
      w[j] = (p ^ rl(p, 15) ^ rl(p, 23)) ^ rl(w[j-13], 7) ^ w[j-6];
    end
    for (int j = 0; j < 8; j++) r[j] = chain[j];
    for (int j = 0; j < 64; j++) begin
      t = (j < 16) ? T_LOW : T_HIGH;
      a12 = rl(r[0], 12);
      ss1 = rl(a12 + r[4] + rl(t, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + r[7] + ss1 + w[j];
      r[3] = r[2]; r[2] = rl(r[1], 9); r[1] = r[0]; r[0] = tt1;
      r[7] = r[6]; r[6] = rl(r[5], 19); r[5] = r[4];
      r[4] = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
    end
    for (int j = 0; j < 8; j++) chain[j] ^= r[j];
  endtask

  task automatic append(input logic [7:0] b);
    if (pos[1:0] == 2'd0) blk[pos[5:2]] = {b, 24'd0};
    else blk[pos[5:2]] |= 32'(b) << ((3 - pos[1:0]) * 8);
    pos = pos + 6'd1;
    if (pos == 6'd0) compress();
  endtask

  task automatic restart();
    for (int k = 0; k < 8; k++) chain[k] = IV[255 - 32*k -: 32];
    bit_len = '0;
    pos = '0;
  endtask

  task automatic absorb(input sm3_in_t it);
    logic [63:0] len;
    sm3_out_t o;
    if (it.byte_valid) begin
      append(it.data_byte);
      bit_len += 64'd8;
    end
    if (it.last) begin
      len = bit_len;
      append(PAD_MARK);
      while (pos != 6'd56) append(8'd0);
      for (int k = 7; k >= 0; k--) append(len[8*k +: 8]);
      for (int k = 0; k < 8; k++) begin
        o.digest_word = chain[k];
        o.word_index = 3'(k);
        o.final_word = (k == 7);
        digest_q.push_back(o);
      end
      restart();
    end
  endtask

  assign pending = digest_q.size();

  always @(posedge clk) begin
    sm3_out_t exp_w;
    if (rst) begin
      restart();
      digest_q.delete();
      fail_count <= 0;
    end else begin
      // check before absorbing: a digest never leaves in the cycle its last arrives
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_data.digest_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w != out_data) begin
            if (exp_w.digest_word != out_data.digest_word)
              $error("digest_word expected %h actual %h", exp_w.digest_word,
                     out_data.digest_word);
            if (exp_w.word_index != out_data.word_index)
              $error("word_index expected %0d actual %0d", exp_w.word_index,
                     out_data.word_index);
            if (exp_w.final_word != out_data.final_word)
              $error("final_word expected %0d actual %0d", exp_w.final_word,
                     out_data.final_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) absorb(in_data);
    end
  end

endmodule

// ----- bench/sm3_hash_engine_test.sv -----
`timescale 1ns / 1ps
// Top of the SM3 hash engine bench: clock, reset, message stimulus, verdict.
// Depends on sm3_pkg, sm3_hash_engine and sm3_digest_checker.
module sm3_hash_engine_test;
  import sm3_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sm3_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sm3_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  int       items_sent = 0;
  bit       calm = 1'b0;   // no idling on either side once set

  always #4 clk = ~clk;

  sm3_hash_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  sm3_digest_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Timeout guard: covers every long-message compression plus stalls many times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sm3_hash_engine] ERROR");
      $finish;
    end
  end

  // Receiver stall: random bursts, none in the calm tail.
  initial begin : out_stall_gen
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Present one transfer and hold it until the engine accepts it.
  task automatic send(input logic [7:0] b, input logic bv, input logic lst);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, byte_valid: bv, last: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Send a message of n random bytes; end it on the last byte, or with an
  // empty last transfer when tail_empty is set. Idle transfers sprinkled in.
  task automatic message(input int n, input bit tail_empty);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send(8'($urandom), 1'b0, 1'b0);
      send(8'($urandom), 1'b1, (i == n - 1) && !tail_empty);
    end
    if (tail_empty || n == 0) send(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, "abc", byte extremes, idle transfers.
    send(8'h00, 1'b0, 1'b1);
    send(8'h61, 1'b1, 1'b0);
    send(8'h62, 1'b1, 1'b0);
    send(8'hff, 1'b0, 1'b0);
    send(8'h63, 1'b1, 1'b1);
    send(8'hff, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'h55, 1'b0, 1'b1);
    send(8'haa, 1'b1, 1'b1);

    // Hold the sender until all digests are out.
    while (pending != 0) @(posedge clk);
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);

    // Padding boundaries: 55 bytes fit one block, 56 need a second.
    message(55, 1'b0);
    message(56, 1'b0);

    // Random short messages; calm tail at the end.
    while (items_sent < 150) begin
      if (items_sent > 125) calm = 1'b1;
      message($urandom_range(0, 12), $urandom_range(0, 3) == 0);
    end
    calm = 1'b1;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sm3_hash_engine] OK");
    end else begin
      $display("[sm3_hash_engine] ERROR");
    end
    $finish;
  end

endmodule
